FILE: hw/rtl/aabbrt_pkg.sv
// Shared types and constants for the rigid-frame box bounds pipeline.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package aabbrt_pkg;

    localparam int ROT_ENTRY_WIDTH = 18;
    localparam int ROW_WIDTH       = 3 * ROT_ENTRY_WIDTH;
    localparam int AXIS_COUNT      = 3;
    localparam int CFG_INDEX_WIDTH = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_ROT_ROW_X = 3'd0,
        REG_ROT_ROW_Y = 3'd1,
        REG_ROT_ROW_Z = 3'd2,
        REG_SHIFT_X   = 3'd3,
        REG_SHIFT_Y   = 3'd4,
        REG_SHIFT_Z   = 3'd5
    } cfg_reg_t;

    // Load strobes for the four register stages of the datapath.
    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
        logic load4;
    } pipe_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/aabbrt_cfg_regs.sv
// Configuration register file: three rotation rows and the translation.
// Depends on aabbrt_pkg.
`default_nettype none

module aabbrt_cfg_regs
    import aabbrt_pkg::*;
#(
    parameter int COORD_WIDTH   = 32,
    parameter int ROT_FRAC_BITS = 16,
    parameter int DATA_WIDTH    = 54
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  wire logic [DATA_WIDTH-1:0]         cfg_data,
    output logic [ROW_WIDTH-1:0]               rot_row [AXIS_COUNT],
    output logic signed [COORD_WIDTH-1:0]      shift [AXIS_COUNT]
);

    logic [ROW_WIDTH-1:0]          row_reg [AXIS_COUNT];
    logic signed [COORD_WIDTH-1:0] shift_reg [AXIS_COUNT];

    // Writes are always taken; an index beyond the list is dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // Identity frame: a one on the diagonal of each row.
            row_reg[0]   <= ROW_WIDTH'(1) << ROT_FRAC_BITS;
            row_reg[1]   <= ROW_WIDTH'(1) << (ROT_FRAC_BITS + ROT_ENTRY_WIDTH);
            row_reg[2]   <= ROW_WIDTH'(1) << (ROT_FRAC_BITS + 2 * ROT_ENTRY_WIDTH);
            shift_reg[0] <= '0;
            shift_reg[1] <= '0;
            shift_reg[2] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ROT_ROW_X: row_reg[0]   <= cfg_data[ROW_WIDTH-1:0];
                REG_ROT_ROW_Y: row_reg[1]   <= cfg_data[ROW_WIDTH-1:0];
                REG_ROT_ROW_Z: row_reg[2]   <= cfg_data[ROW_WIDTH-1:0];
                REG_SHIFT_X:   shift_reg[0] <= $signed(cfg_data[COORD_WIDTH-1:0]);
                REG_SHIFT_Y:   shift_reg[1] <= $signed(cfg_data[COORD_WIDTH-1:0]);
                REG_SHIFT_Z:   shift_reg[2] <= $signed(cfg_data[COORD_WIDTH-1:0]);
                default:
                begin
                end
            endcase
        end
    end

    assign rot_row   = row_reg;
    assign shift     = shift_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/aabbrt_axis_path.sv
// Datapath for one world axis: products, per-term bounds, sums, saturation.
// Depends on aabbrt_pkg; stage strobes come from the top level.
`default_nettype none

module aabbrt_axis_path
    import aabbrt_pkg::*;
#(
    parameter int COORD_WIDTH   = 32,
    parameter int ROT_FRAC_BITS = 16
)
(
    input  wire logic                          clk,
    input  wire pipe_ctrl_t                    ctrl,
    input  wire logic [ROW_WIDTH-1:0]          rot_row,
    input  wire logic signed [COORD_WIDTH-1:0] shift,
    input  wire logic signed [COORD_WIDTH-1:0] low [AXIS_COUNT],
    input  wire logic signed [COORD_WIDTH-1:0] high [AXIS_COUNT],
    output logic signed [COORD_WIDTH-1:0]      world_min,
    output logic signed [COORD_WIDTH-1:0]      world_max
);

    localparam int PW = ROT_ENTRY_WIDTH + COORD_WIDTH;
    localparam int TW = PW - ROT_FRAC_BITS;
    localparam int SW = ((TW > COORD_WIDTH) ? TW : COORD_WIDTH) + 2;

    logic signed [ROT_ENTRY_WIDTH-1:0] entry [AXIS_COUNT];
    logic signed [PW-1:0]              prod_lo_reg [AXIS_COUNT];
    logic signed [PW-1:0]              prod_hi_reg [AXIS_COUNT];
    logic signed [TW-1:0]              term_lo [AXIS_COUNT];
    logic signed [TW-1:0]              term_hi [AXIS_COUNT];
    logic signed [TW-1:0]              term_min_reg [AXIS_COUNT];
    logic signed [TW-1:0]              term_max_reg [AXIS_COUNT];
    logic signed [SW-1:0]              sum_min_reg;
    logic signed [SW-1:0]              sum_max_reg;
    logic signed [SW-1:0]              sum_min_next;
    logic signed [SW-1:0]              sum_max_next;
    logic signed [COORD_WIDTH-1:0]     min_reg;
    logic signed [COORD_WIDTH-1:0]     max_reg;
    logic signed [COORD_WIDTH-1:0]     min_next;
    logic signed [COORD_WIDTH-1:0]     max_next;

    always_comb
    begin
        for (int b = 0; b < AXIS_COUNT; b++)
        begin
            entry[b]   = $signed(rot_row[ROT_ENTRY_WIDTH*b +: ROT_ENTRY_WIDTH]);
            // Arithmetic shift right by the fraction bits, kept as a part-select.
            term_lo[b] = $signed(prod_lo_reg[b][PW-1:ROT_FRAC_BITS]);
            term_hi[b] = $signed(prod_hi_reg[b][PW-1:ROT_FRAC_BITS]);
        end
    end

    // Stage 1: both candidate products for every local axis.
    always_ff @(posedge clk)
    begin
        if (ctrl.load1)
        begin
            for (int b = 0; b < AXIS_COUNT; b++)
            begin
                prod_lo_reg[b] <= PW'(entry[b]) * PW'(low[b]);
                prod_hi_reg[b] <= PW'(entry[b]) * PW'(high[b]);
            end
        end
    end

    // Stage 2: each term depends on one corner coordinate only, so the
    // extreme over the eight corners is the sum of per-term extremes.
    always_ff @(posedge clk)
    begin
        if (ctrl.load2)
        begin
            for (int b = 0; b < AXIS_COUNT; b++)
            begin
                term_min_reg[b] <= (term_lo[b] < term_hi[b]) ? term_lo[b] : term_hi[b];
                term_max_reg[b] <= (term_lo[b] < term_hi[b]) ? term_hi[b] : term_lo[b];
            end
        end
    end

    // Stage 3: exact sums with the translation.
    always_comb
    begin
        sum_min_next = SW'(term_min_reg[0]) + SW'(term_min_reg[1])
                     + SW'(term_min_reg[2]) + SW'(shift);
        sum_max_next = SW'(term_max_reg[0]) + SW'(term_max_reg[1])
                     + SW'(term_max_reg[2]) + SW'(shift);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load3)
        begin
            sum_min_reg <= sum_min_next;
            sum_max_reg <= sum_max_next;
        end
    end

    // Stage 4: saturate to the coordinate range; this is the output register.
    always_comb
    begin
        if (sum_min_reg[SW-1:COORD_WIDTH-1] == {(SW-COORD_WIDTH+1){sum_min_reg[SW-1]}})
        begin
            min_next = sum_min_reg[COORD_WIDTH-1:0];
        end
        else
        begin
            min_next = {sum_min_reg[SW-1], {(COORD_WIDTH-1){~sum_min_reg[SW-1]}}};
        end
        if (sum_max_reg[SW-1:COORD_WIDTH-1] == {(SW-COORD_WIDTH+1){sum_max_reg[SW-1]}})
        begin
            max_next = sum_max_reg[COORD_WIDTH-1:0];
        end
        else
        begin
            max_next = {sum_max_reg[SW-1], {(COORD_WIDTH-1){~sum_max_reg[SW-1]}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load4)
        begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    assign world_min = min_reg;
    assign world_max = max_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/aabb_rigid_transform_bounds.sv
// Top level of the rigid-frame box bounds pipeline: handshakes, stage valids.
// Depends on aabbrt_pkg, aabbrt_cfg_regs and aabbrt_axis_path.
`default_nettype none

// Maps a local axis-aligned box through world = R * corner + T and returns the
// axis-aligned box bounding the eight mapped corners, per-axis minimum and
// maximum, in signed fixed point with saturation. One box is accepted every
// cycle unless back-pressure fills the pipeline; a box passes through four
// register stages: multiply, per-term bound, sum, saturate. A stalled output
// holds the pipeline only as far back as stages are full, so bubbles close up.
// The user must write R and T on the configuration port only while no box is
// in flight; the block does not enforce it. Reset loads the identity frame.
module aabb_rigid_transform_bounds
    import aabbrt_pkg::*;
#(
    parameter int COORD_WIDTH   = 32,
    parameter int ROT_FRAC_BITS = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  wire logic [((COORD_WIDTH > ROW_WIDTH) ? COORD_WIDTH : ROW_WIDTH)-1:0] cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] in_low_x,
    input  wire logic signed [COORD_WIDTH-1:0] in_low_y,
    input  wire logic signed [COORD_WIDTH-1:0] in_low_z,
    input  wire logic signed [COORD_WIDTH-1:0] in_high_x,
    input  wire logic signed [COORD_WIDTH-1:0] in_high_y,
    input  wire logic signed [COORD_WIDTH-1:0] in_high_z,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0]      out_low_x,
    output logic signed [COORD_WIDTH-1:0]      out_low_y,
    output logic signed [COORD_WIDTH-1:0]      out_low_z,
    output logic signed [COORD_WIDTH-1:0]      out_high_x,
    output logic signed [COORD_WIDTH-1:0]      out_high_y,
    output logic signed [COORD_WIDTH-1:0]      out_high_z
);

    localparam int DATA_WIDTH = (COORD_WIDTH > ROW_WIDTH) ? COORD_WIDTH : ROW_WIDTH;

    logic [ROW_WIDTH-1:0]          rot_row [AXIS_COUNT];
    logic signed [COORD_WIDTH-1:0] shift [AXIS_COUNT];
    logic signed [COORD_WIDTH-1:0] box_low [AXIS_COUNT];
    logic signed [COORD_WIDTH-1:0] box_high [AXIS_COUNT];
    logic signed [COORD_WIDTH-1:0] world_min [AXIS_COUNT];
    logic signed [COORD_WIDTH-1:0] world_max [AXIS_COUNT];

    logic       v1_reg, v2_reg, v3_reg, v4_reg;
    logic       v1_next, v2_next, v3_next, v4_next;
    logic       ready1, ready2, ready3, ready4;
    pipe_ctrl_t ctrl;

    aabbrt_cfg_regs #(
        .COORD_WIDTH   (COORD_WIDTH),
        .ROT_FRAC_BITS (ROT_FRAC_BITS),
        .DATA_WIDTH    (DATA_WIDTH)
    ) u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rot_row   (rot_row),
        .shift     (shift)
    );

    // A stage takes a new beat when it is empty or its content moves on.
    always_comb
    begin
        ready4     = !v4_reg || out_ready;
        ready3     = !v3_reg || ready4;
        ready2     = !v2_reg || ready3;
        ready1     = !v1_reg || ready2;
        ctrl.load1 = ready1 && in_valid;
        ctrl.load2 = ready2 && v1_reg;
        ctrl.load3 = ready3 && v2_reg;
        ctrl.load4 = ready4 && v3_reg;
        v1_next    = ready1 ? in_valid : v1_reg;
        v2_next    = ready2 ? v1_reg   : v2_reg;
        v3_next    = ready3 ? v2_reg   : v3_reg;
        v4_next    = ready4 ? v3_reg   : v4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign in_ready  = ready1;
    assign out_valid = v4_reg;

    assign box_low[0]  = in_low_x;
    assign box_low[1]  = in_low_y;
    assign box_low[2]  = in_low_z;
    assign box_high[0] = in_high_x;
    assign box_high[1] = in_high_y;
    assign box_high[2] = in_high_z;

    for (genvar a = 0; a < AXIS_COUNT; a++)
    begin : g_axis
        aabbrt_axis_path #(
            .COORD_WIDTH   (COORD_WIDTH),
            .ROT_FRAC_BITS (ROT_FRAC_BITS)
        ) u_axis_path (
            .clk       (clk),
            .ctrl      (ctrl),
            .rot_row   (rot_row[a]),
            .shift     (shift[a]),
            .low       (box_low),
            .high      (box_high),
            .world_min (world_min[a]),
            .world_max (world_max[a])
        );
    end

    assign out_low_x  = world_min[0];
    assign out_low_y  = world_min[1];
    assign out_low_z  = world_min[2];
    assign out_high_x = world_max[0];
    assign out_high_y = world_max[1];
    assign out_high_z = world_max[2];

`ifndef SYNTHESIS
    // A beat entering an empty pipeline passes through every stage register without a stall and reaches the output.
    a_empty_latency: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !v1_reg && !v2_reg && !v3_reg && !v4_reg)
            |-> ##4 out_valid
    ) else $error("beat did not reach the output through an empty pipeline");

    // The bounds are always ordered, whatever the frame or the input box.
    a_bounds_ordered: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_low_x <= out_high_x) && (out_low_y <= out_high_y)
                      && (out_low_z <= out_high_z)
    ) else $error("output minimum exceeds maximum");

    // A full, stalled pipeline must refuse new input.
    a_full_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && v4_reg && !out_ready) |-> !in_ready
    ) else $error("input accepted while every stage is held");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/aabb_rigid_transform_bounds_tb.sv
// Self-checking testbench for aabb_rigid_transform_bounds: drives boxes and frame writes,
// predicts each bounding box in fixed point and compares every output beat.
// Depends on aabbrt_pkg and the aabb_rigid_transform_bounds RTL only.
module aabb_rigid_transform_bounds_tb
    import aabbrt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W      = 32;
    localparam int FRAC_BITS    = 16;
    localparam int PIPE_LATENCY = 4;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    localparam logic [ROT_ENTRY_WIDTH-1:0] ENTRY_ZERO     = 18'h00000;
    localparam logic [ROT_ENTRY_WIDTH-1:0] ENTRY_ONE      = 18'h10000;
    localparam logic [ROT_ENTRY_WIDTH-1:0] ENTRY_NEG_ONE  = 18'h30000;
    localparam logic [ROT_ENTRY_WIDTH-1:0] ENTRY_HALF     = 18'h08000;
    localparam logic [ROT_ENTRY_WIDTH-1:0] ENTRY_NEG_HALF = 18'h38000;
    localparam logic [ROT_ENTRY_WIDTH-1:0] ENTRY_MAX      = 18'h1FFFF;
    localparam logic [ROT_ENTRY_WIDTH-1:0] ENTRY_MIN      = 18'h20000;

    // Indexes beyond the register file; writes to them must leave the frame alone.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic signed [COORD_W-1:0] low_x;
        logic signed [COORD_W-1:0] low_y;
        logic signed [COORD_W-1:0] low_z;
        logic signed [COORD_W-1:0] high_x;
        logic signed [COORD_W-1:0] high_y;
        logic signed [COORD_W-1:0] high_z;
    } aabb_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [ROW_WIDTH-1:0]       cfg_data  = '0;

    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic signed [COORD_W-1:0] in_low_x  = '0;
    logic signed [COORD_W-1:0] in_low_y  = '0;
    logic signed [COORD_W-1:0] in_low_z  = '0;
    logic signed [COORD_W-1:0] in_high_x = '0;
    logic signed [COORD_W-1:0] in_high_y = '0;
    logic signed [COORD_W-1:0] in_high_z = '0;

    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [COORD_W-1:0] out_low_x;
    logic signed [COORD_W-1:0] out_low_y;
    logic signed [COORD_W-1:0] out_low_z;
    logic signed [COORD_W-1:0] out_high_x;
    logic signed [COORD_W-1:0] out_high_y;
    logic signed [COORD_W-1:0] out_high_z;

    // Frame as the block should hold it; identity after reset.
    logic [ROW_WIDTH-1:0]      frame_row   [3];
    logic signed [COORD_W-1:0] frame_shift [3];

    aabb_t pending_bounds[$];

    int  boxes_sent     = 0;
    int  bounds_checked = 0;
    int  mismatches     = 0;
    int  cfg_writes     = 0;
    int  frames_loaded  = 0;
    int  cycle_count    = 0;
    int  hold_request   = 0;
    int  hold_left      = 0;
    bit  no_idle        = 1'b0;

    aabb_rigid_transform_bounds #(
        .COORD_WIDTH   (COORD_W),
        .ROT_FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_low_x   (in_low_x),
        .in_low_y   (in_low_y),
        .in_low_z   (in_low_z),
        .in_high_x  (in_high_x),
        .in_high_y  (in_high_y),
        .in_high_z  (in_high_z),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_low_x  (out_low_x),
        .out_low_y  (out_low_y),
        .out_low_z  (out_low_z),
        .out_high_x (out_high_x),
        .out_high_y (out_high_y),
        .out_high_z (out_high_z)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // One world coordinate: truncated products plus translation, saturated.
    function automatic logic signed [COORD_W-1:0] map_axis(
        input logic [ROW_WIDTH-1:0]      row,
        input logic signed [COORD_W-1:0] t,
        input logic signed [COORD_W-1:0] c [3]
    );
        logic signed [ROT_ENTRY_WIDTH-1:0] entry;
        logic signed [63:0] prod;
        logic signed [63:0] acc;
        int b;
        acc = 64'(t);
        for (b = 0; b < 3; b++)
        begin
            entry = row[b*ROT_ENTRY_WIDTH +: ROT_ENTRY_WIDTH];
            prod  = 64'(entry) * 64'(c[b]);
            acc   = acc + (prod >>> FRAC_BITS);
        end
        if (acc > SAT_HI)
            return COORD_MAX;
        if (acc < SAT_LO)
            return COORD_MIN;
        return acc[COORD_W-1:0];
    endfunction

    function automatic aabb_t bound_world_box(input aabb_t b);
        logic signed [COORD_W-1:0] lo [3];
        logic signed [COORD_W-1:0] hi [3];
        logic signed [COORD_W-1:0] corner [3];
        logic signed [COORD_W-1:0] mn [3];
        logic signed [COORD_W-1:0] mx [3];
        logic signed [COORD_W-1:0] w;
        aabb_t r;
        int i;
        int a;
        lo[0] = b.low_x;  lo[1] = b.low_y;  lo[2] = b.low_z;
        hi[0] = b.high_x; hi[1] = b.high_y; hi[2] = b.high_z;
        for (i = 0; i < 8; i++)
        begin
            corner[0] = ((i & 4) != 0) ? hi[0] : lo[0];
            corner[1] = ((i & 2) != 0) ? hi[1] : lo[1];
            corner[2] = ((i & 1) != 0) ? hi[2] : lo[2];
            for (a = 0; a < 3; a++)
            begin
                w = map_axis(frame_row[a], frame_shift[a], corner);
                if (i == 0 || w < mn[a])
                    mn[a] = w;
                if (i == 0 || w > mx[a])
                    mx[a] = w;
            end
        end
        r.low_x  = mn[0]; r.low_y  = mn[1]; r.low_z  = mn[2];
        r.high_x = mx[0]; r.high_y = mx[1]; r.high_z = mx[2];
        return r;
    endfunction

    function automatic aabb_t make_box(
        input logic signed [COORD_W-1:0] lx, ly, lz, hx, hy, hz
    );
        aabb_t b;
        b.low_x  = lx; b.low_y  = ly; b.low_z  = lz;
        b.high_x = hx; b.high_y = hy; b.high_z = hz;
        return b;
    endfunction

    function automatic logic [ROW_WIDTH-1:0] pack_row(
        input logic [ROT_ENTRY_WIDTH-1:0] ex, ey, ez
    );
        return {ez, ey, ex};
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       return COORD_MAX;
                    1:       return COORD_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            1, 2, 3: return $urandom;
            default: return int'($urandom_range(0, 2097152)) - 1048576;
        endcase
    endfunction

    function automatic aabb_t rand_box();
        aabb_t b;
        logic signed [COORD_W-1:0] t;
        b = make_box(rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord());
        // Mostly well-ordered boxes; the rest are left as drawn and may be inverted on some axes.
        if ($urandom_range(0, 4) != 0)
        begin
            if (b.low_x > b.high_x) begin t = b.low_x; b.low_x = b.high_x; b.high_x = t; end
            if (b.low_y > b.high_y) begin t = b.low_y; b.low_y = b.high_y; b.high_y = t; end
            if (b.low_z > b.high_z) begin t = b.low_z; b.low_z = b.high_z; b.high_z = t; end
        end
        return b;
    endfunction

    function automatic logic [ROT_ENTRY_WIDTH-1:0] rand_entry();
        logic [ROT_ENTRY_WIDTH-1:0] e;
        case ($urandom_range(0, 5))
            0: e = ROT_ENTRY_WIDTH'($urandom);
            1:
            begin
                case ($urandom_range(0, 4))
                    0:       e = ENTRY_MAX;
                    1:       e = ENTRY_MIN;
                    2:       e = ENTRY_ONE;
                    3:       e = ENTRY_NEG_ONE;
                    default: e = ENTRY_ZERO;
                endcase
            end
            default: e = ROT_ENTRY_WIDTH'(int'($urandom_range(0, 131072)) - 65536);
        endcase
        return e;
    endfunction

    function automatic logic [ROW_WIDTH-1:0] rand_row();
        if ($urandom_range(0, 4) == 0)
            return ROW_WIDTH'({$urandom, $urandom});
        return pack_row(rand_entry(), rand_entry(), rand_entry());
    endfunction

    task automatic check_field(input string name, input logic signed [COORD_W-1:0] want,
                               input logic signed [COORD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_bounds();
        aabb_t want;
        if (pending_bounds.size() == 0)
        begin
            $error("result beat with no box outstanding");
            mismatches++;
        end
        else
        begin
            want = pending_bounds.pop_front();
            check_field("out_low_x", want.low_x, out_low_x);
            check_field("out_low_y", want.low_y, out_low_y);
            check_field("out_low_z", want.low_z, out_low_z);
            check_field("out_high_x", want.high_x, out_high_x);
            check_field("out_high_y", want.high_y, out_high_y);
            check_field("out_high_z", want.high_z, out_high_z);
            bounds_checked++;
        end
    endtask

    // Result side: checks each beat and drives out_ready with random hold-offs.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_bounds();
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            out_ready <= 1'b0;
            hold_left = $urandom_range(0, 7);
        end
        else
            out_ready <= 1'b1;
    end

    // Valid is left high after the beat so back-to-back boxes need no extra edge.
    task automatic send_box(input aabb_t b);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_low_x  <= b.low_x;
        in_low_y  <= b.low_y;
        in_low_z  <= b.low_z;
        in_high_x <= b.high_x;
        in_high_y <= b.high_y;
        in_high_z <= b.high_z;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_bounds.push_back(bound_world_box(b));
        boxes_sent++;
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_bounds.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after its last write.
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [ROW_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_ROT_ROW_X: frame_row[0]   = data;
            REG_ROT_ROW_Y: frame_row[1]   = data;
            REG_ROT_ROW_Z: frame_row[2]   = data;
            REG_SHIFT_X:   frame_shift[0] = data[COORD_W-1:0];
            REG_SHIFT_Y:   frame_shift[1] = data[COORD_W-1:0];
            REG_SHIFT_Z:   frame_shift[2] = data[COORD_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Shift writes carry random junk above bit 31, which the block must drop.
    task automatic load_frame(input logic [ROW_WIDTH-1:0] rx, ry, rz,
                              input logic signed [COORD_W-1:0] tx, ty, tz);
        write_reg(REG_ROT_ROW_X, rx);
        write_reg(REG_ROT_ROW_Y, ry);
        write_reg(REG_ROT_ROW_Z, rz);
        write_reg(REG_SHIFT_X, ROW_WIDTH'({$urandom, tx}));
        write_reg(REG_SHIFT_Y, ROW_WIDTH'({$urandom, ty}));
        write_reg(REG_SHIFT_Z, ROW_WIDTH'({$urandom, tz}));
        cfg_valid <= 1'b0;
        frames_loaded++;
    endtask

    task automatic load_random_frame();
        load_frame(rand_row(), rand_row(), rand_row(), rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic test_reset_frame();
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(-65536, -65536, -65536, 65536, 65536, 65536));
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
        send_box(make_box(32'sh0001_8000, -7, 3, -1, 32'sh0002_0001, -5));
        drain_pipeline();
    endtask

    task automatic test_rotation_frames();
        // Quarter turn about z with a translation.
        load_frame(pack_row(ENTRY_ZERO, ENTRY_NEG_ONE, ENTRY_ZERO),
                   pack_row(ENTRY_ONE, ENTRY_ZERO, ENTRY_ZERO),
                   pack_row(ENTRY_ZERO, ENTRY_ZERO, ENTRY_ONE),
                   32'sh0005_8000, -32'sh0003_0000, 32'sh0064_0000);
        send_box(make_box(-65536, 0, 0, 131072, 65536, 196608));
        send_box(make_box(32'sh0010_0000, -32'sh0004_0000, -3, 32'sh0020_0000, 32'sh0001_0000, 9));
        send_box(make_box(5, 5, 5, -5, -5, -5));
        drain_pipeline();
        // Half entries with odd coordinates exercise truncation toward minus infinity.
        load_frame(pack_row(ENTRY_HALF, ENTRY_NEG_HALF, ENTRY_ZERO),
                   pack_row(ENTRY_HALF, ENTRY_HALF, ENTRY_ZERO),
                   pack_row(ENTRY_ZERO, ENTRY_ZERO, ENTRY_NEG_ONE),
                   0, 0, -1);
        send_box(make_box(-3, 5, -7, 9, -11, 13));
        send_box(make_box(1, 1, 1, 1, 1, 1));
        drain_pipeline();
    endtask

    task automatic test_saturation();
        load_frame(pack_row(ENTRY_MAX, ENTRY_MAX, ENTRY_MAX),
                   pack_row(ENTRY_MIN, ENTRY_MIN, ENTRY_MIN),
                   pack_row(ENTRY_MAX, ENTRY_MIN, ENTRY_ONE),
                   COORD_MAX, COORD_MIN, COORD_MIN);
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        send_box(make_box(0, 0, 0, 1, 1, 1));
        drain_pipeline();
        load_frame(pack_row(ENTRY_ZERO, ENTRY_ZERO, ENTRY_ZERO),
                   pack_row(ENTRY_ZERO, ENTRY_ZERO, ENTRY_ZERO),
                   pack_row(ENTRY_ZERO, ENTRY_ZERO, ENTRY_ZERO),
                   COORD_MAX, COORD_MIN, 0);
        send_box(make_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
        drain_pipeline();
    endtask

    task automatic test_unused_index();
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, ROW_WIDTH'({$urandom, $urandom}));
        cfg_valid <= 1'b0;
        send_box(make_box(-65536, 65536, -1, 65536, -65536, 1));
        send_box(make_box(32'sh0100_0000, -32'sh0100_0000, 0, 7, 7, 7));
        drain_pipeline();
    endtask

    task automatic test_random_frames();
        int p;
        int n;
        for (p = 0; p < 6; p++)
        begin
            load_random_frame();
            for (n = 0; n < 120; n++)
                send_box(rand_box());
            drain_pipeline();
        end
    endtask

    // The receiver stalls long enough for the pipeline to fill and push back.
    task automatic test_backpressure();
        int n;
        load_random_frame();
        hold_request = 300;
        for (n = 0; n < 80; n++)
            send_box(rand_box());
        drain_pipeline();
    endtask

    task automatic test_streaming();
        int n;
        no_idle = 1'b1;
        load_random_frame();
        for (n = 0; n < 130; n++)
            send_box(rand_box());
        drain_pipeline();
    endtask

    initial
    begin
        frame_row[0]   = pack_row(ENTRY_ONE, ENTRY_ZERO, ENTRY_ZERO);
        frame_row[1]   = pack_row(ENTRY_ZERO, ENTRY_ONE, ENTRY_ZERO);
        frame_row[2]   = pack_row(ENTRY_ZERO, ENTRY_ZERO, ENTRY_ONE);
        frame_shift[0] = '0;
        frame_shift[1] = '0;
        frame_shift[2] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_frame();
        test_rotation_frames();
        test_saturation();
        test_unused_index();
        test_random_frames();
        test_backpressure();
        test_streaming();

        if (pending_bounds.size() != 0)
        begin
            $error("%0d expected boxes never came out", pending_bounds.size());
            mismatches++;
        end
        $display("Sent %0d boxes through %0d frames with %0d register writes.",
                 boxes_sent, frames_loaded, cfg_writes);
        $display("Compared %0d bounding boxes, %0d field mismatches.",
                 bounds_checked, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: aabb_rigid_transform_bounds.f
hw/rtl/aabbrt_pkg.sv
hw/rtl/aabbrt_cfg_regs.sv
hw/rtl/aabbrt_axis_path.sv
hw/rtl/aabb_rigid_transform_bounds.sv
tb/sv/aabb_rigid_transform_bounds_tb.sv
